>>> hdl/hta_pkg.sv
// Shared constants, types and helper functions for the heater temperature averager
package hta_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned AVG_W    = 9;
  localparam int unsigned PROD_W   = 24;

  // overheat threshold and window length (last count value closes the window)
  localparam logic [SAMPLE_W-1:0] OVERHEAT_LEVEL = 8'd95;
  localparam logic [COUNT_W-1:0]  WINDOW_LAST    = 4'd9;
  localparam logic [AVG_W:0]      HYST_BAND      = 10'd5;

  // band edges for the offset correction
  localparam logic [SAMPLE_W-1:0] BAND_EDGE_1 = 8'd15;
  localparam logic [SAMPLE_W-1:0] BAND_EDGE_2 = 8'd32;
  localparam logic [SAMPLE_W-1:0] BAND_EDGE_3 = 8'd50;
  localparam logic [SAMPLE_W-1:0] BAND_EDGE_4 = 8'd68;
  localparam logic [SAMPLE_W-1:0] BAND_EDGE_5 = 8'd86;

  // divide by ten as multiply by 3277 / 2^15, exact for any 12-bit sum
  localparam logic [PROD_W-1:0] DIV10_MUL   = 24'd3277;
  localparam int unsigned       DIV10_SHIFT = 15;

  // decade correction applies for averages from 10 up to 99
  localparam logic [AVG_W-1:0] DECADE_LOW  = 9'd10;
  localparam logic [AVG_W-1:0] DECADE_HIGH = 9'd100;

  localparam logic [SAMPLE_W-1:0] SETPOINT_RESET = 8'd60;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic               heat;
    logic               cool;
    logic               alarm;
  } hta_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] corrected_temp;
    logic                average_ready;
    logic [SAMPLE_W-1:0] averaged_temp;
    logic                heat_on;
    logic                cool_on;
    logic                overheat_alarm;
  } hta_result_t;

  // offset to subtract for a sample below the overheat level
  function automatic logic [2:0] band_offset(input logic [SAMPLE_W-1:0] s);
    logic [2:0] off;
    if (s < BAND_EDGE_1)      off = 3'd0;
    else if (s < BAND_EDGE_2) off = 3'd1;
    else if (s < BAND_EDGE_3) off = 3'd2;
    else if (s < BAND_EDGE_4) off = 3'd3;
    else if (s < BAND_EDGE_5) off = 3'd4;
    else                      off = 3'd5;
    return off;
  endfunction

  // tens digit of a value below 100, by nine parallel compares
  function automatic logic [3:0] tens_digit(input logic [AVG_W-1:0] a);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (a >= AVG_W'(10 * k)) d = d + 4'd1;
    end
    return d;
  endfunction

endpackage

>>> hdl/heater_temp_average_hysteresis_top.sv
// Top level: handshakes, window state, set-temperature register and result register
// A result is valid the cycle after its sample request is accepted.
// Throughput: one request per cycle while results are taken; the single result register frees as it is read.
// The whole per-sample datapath sits between the input ports and the result register.
// Reset (rst_n low, synchronous): window count, sum, heat, cool and alarm cleared,
// no result pending, set temperature back to 60.
module heater_temp_average_hysteresis_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hta_pkg::SAMPLE_W-1:0] in_sensor_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hta_pkg::SAMPLE_W-1:0] out_corrected_temp,
  output logic                         out_average_ready,
  output logic [hta_pkg::SAMPLE_W-1:0] out_averaged_temp,
  output logic                         out_heat_on,
  output logic                         out_cool_on,
  output logic                         out_overheat_alarm,
  input  logic                         cfg_wr_en,
  input  logic [hta_pkg::SAMPLE_W-1:0] cfg_wr_data
);
  import hta_pkg::*;

  hta_state_t          state_r;
  hta_state_t          state_nxt;
  hta_result_t         res_r;
  hta_result_t         res_nxt;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] setpoint_r;
  logic                accept;

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  hta_window u_window (
    .sample   (in_sensor_sample),
    .setpoint (setpoint_r),
    .cur      (state_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  // set temperature register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RESET;
    end else if (cfg_wr_en) begin
      setpoint_r <= cfg_wr_data;
    end
  end

  // window state advances on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_corrected_temp = res_r.corrected_temp;
  assign out_average_ready  = res_r.average_ready;
  assign out_averaged_temp  = res_r.averaged_temp;
  assign out_heat_on        = res_r.heat_on;
  assign out_cool_on        = res_r.cool_on;
  assign out_overheat_alarm = res_r.overheat_alarm;

endmodule

>>> hdl/hta_window.sv
// Per-sample datapath: offset correction, window accumulate, average and hysteresis
module hta_window (
  input  logic [hta_pkg::SAMPLE_W-1:0] sample,
  input  logic [hta_pkg::SAMPLE_W-1:0] setpoint,
  input  hta_pkg::hta_state_t          cur,
  output hta_pkg::hta_state_t          nxt,
  output hta_pkg::hta_result_t         res
);
  import hta_pkg::*;

  logic                over;
  logic [SAMPLE_W-1:0] corr;
  logic [SUM_W-1:0]    sum_acc;
  logic                close;
  logic [PROD_W-1:0]   prod;
  logic [AVG_W-1:0]    quot;
  logic [AVG_W-1:0]    avg;
  logic                want_heat;
  logic                want_cool;

  // offset correction; overheat readings pass as they are
  assign over = (sample >= OVERHEAT_LEVEL);
  assign corr = over ? sample : (sample - {5'b0, band_offset(sample)});

  // accumulate and test for window end
  assign sum_acc = cur.sum + {{(SUM_W-SAMPLE_W){1'b0}}, corr};
  assign close   = (cur.count >= WINDOW_LAST);

  // window average by reciprocal multiply, then decade correction
  assign prod = PROD_W'(sum_acc) * DIV10_MUL;
  assign quot = prod[DIV10_SHIFT +: AVG_W];
  assign avg  = ((quot >= DECADE_LOW) && (quot < DECADE_HIGH)) ?
                (quot - {5'b0, tens_digit(quot)}) : quot;

  // hysteresis band around the set temperature
  assign want_heat = ({1'b0, avg} + HYST_BAND) < {2'b0, setpoint};
  assign want_cool = {1'b0, avg} > ({2'b0, setpoint} + HYST_BAND);

  // next state
  always_comb begin
    nxt.alarm = cur.alarm | over;
    if (close) begin
      nxt.count = '0;
      nxt.sum   = '0;
      nxt.heat  = want_heat;
      nxt.cool  = want_cool & ~want_heat;
    end else begin
      nxt.count = cur.count + COUNT_W'(1);
      nxt.sum   = sum_acc;
      nxt.heat  = cur.heat;
      nxt.cool  = cur.cool;
    end
  end

  // result fields
  always_comb begin
    res.corrected_temp = corr;
    res.average_ready  = close;
    res.averaged_temp  = close ? avg[SAMPLE_W-1:0] : '0;
    res.heat_on        = nxt.heat;
    res.cool_on        = nxt.cool;
    res.overheat_alarm = nxt.alarm;
  end

endmodule

>>> hdl/hta_checker.sv
// Port-level checks for the heater temperature averager, bound to the top level
module hta_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [hta_pkg::SAMPLE_W-1:0] in_sensor_sample,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [hta_pkg::SAMPLE_W-1:0] out_averaged_temp,
  input logic                         out_average_ready,
  input logic                         out_heat_on,
  input logic                         out_cool_on,
  input logic                         out_overheat_alarm
);
  import hta_pkg::*;

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // overheat request shows the alarm in its result
  a_alarm_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_sensor_sample >= OVERHEAT_LEVEL)
    |=> out_valid && out_overheat_alarm)
    else $error("overheat sample did not raise the alarm");

  // alarm stays set while results follow without a gap
  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overheat_alarm |=> !out_valid || out_overheat_alarm)
    else $error("overheat alarm cleared without reset");

  // heat and cool never drive together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_heat_on && out_cool_on))
    else $error("heat and cool both on");

  // average reads zero outside a window end
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_ready |-> out_averaged_temp == '0)
    else $error("average shown without window end");

endmodule

bind heater_temp_average_hysteresis_top hta_checker u_hta_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_sensor_sample   (in_sensor_sample),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_averaged_temp  (out_averaged_temp),
  .out_average_ready  (out_average_ready),
  .out_heat_on        (out_heat_on),
  .out_cool_on        (out_cool_on),
  .out_overheat_alarm (out_overheat_alarm)
);

>>> tb/heater_temp_average_hysteresis_top_tb.sv
// Testbench for the heater temperature averager: randomized requests checked against a predictor
`timescale 1ns / 100ps
module heater_temp_average_hysteresis_top_tb;
  import hta_pkg::*;

  localparam int WINDOW_LEN        = 10;
  localparam int DECADE            = 10;
  localparam int WINDOWS_PER_PHASE = 22;
  localparam int SETTLE_CYCLES     = 4;
  localparam int LONG_HOLD         = 50;
  localparam int HOLD_AT_RESULT    = 300;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sensor_sample = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [SAMPLE_W-1:0] out_corrected_temp;
  logic                out_average_ready;
  logic [SAMPLE_W-1:0] out_averaged_temp;
  logic                out_heat_on;
  logic                out_cool_on;
  logic                out_overheat_alarm;
  logic                cfg_wr_en        = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wr_data      = '0;

  // predicted block state
  logic [SAMPLE_W-1:0] setpoint_q = SETPOINT_RESET;
  logic [COUNT_W-1:0]  count_q    = '0;
  logic [SUM_W-1:0]    sum_q      = '0;
  logic                heat_q     = 1'b0;
  logic                cool_q     = 1'b0;
  logic                alarm_q    = 1'b0;

  hta_result_t         expected_results[$];
  logic [SAMPLE_W-1:0] pending_samples[$];

  int samples_queued   = 0;
  int samples_accepted = 0;
  int results_checked  = 0;
  int errors           = 0;
  int heat_windows     = 0;
  int cool_windows     = 0;
  int band_windows     = 0;
  bit idle_enable      = 1'b1;
  bit in_taken         = 1'b0;
  int send_gap         = 0;
  int recv_gap         = 0;
  int hold_left        = 0;
  bit hold_done        = 1'b0;

  heater_temp_average_hysteresis_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sensor_sample   (in_sensor_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_corrected_temp (out_corrected_temp),
    .out_average_ready  (out_average_ready),
    .out_averaged_temp  (out_averaged_temp),
    .out_heat_on        (out_heat_on),
    .out_cool_on        (out_cool_on),
    .out_overheat_alarm (out_overheat_alarm),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // band correction, window sum and hysteresis decision for one sample
  function automatic hta_result_t step_window(input logic [SAMPLE_W-1:0] sample);
    hta_result_t         r;
    logic [SAMPLE_W-1:0] corr;
    int                  avg;
    int                  lo;
    int                  hi;
    r = '0;
    if (sample >= OVERHEAT_LEVEL) begin
      corr    = sample;
      alarm_q = 1'b1;
    end else begin
      // one degree off for every band edge at or below the sample
      corr = sample - SAMPLE_W'(sample >= BAND_EDGE_1) - SAMPLE_W'(sample >= BAND_EDGE_2)
                    - SAMPLE_W'(sample >= BAND_EDGE_3) - SAMPLE_W'(sample >= BAND_EDGE_4)
                    - SAMPLE_W'(sample >= BAND_EDGE_5);
    end
    sum_q = sum_q + SUM_W'(corr);
    if (count_q >= WINDOW_LAST) begin
      avg = int'(sum_q) / WINDOW_LEN;
      if (avg >= int'(DECADE_LOW) && avg < int'(DECADE_HIGH)) begin
        avg = avg - avg / DECADE;
      end
      lo     = int'(setpoint_q) - int'(HYST_BAND);
      hi     = int'(setpoint_q) + int'(HYST_BAND);
      heat_q = (avg < lo);
      cool_q = (avg > hi);
      r.average_ready = 1'b1;
      r.averaged_temp = SAMPLE_W'(avg);
      count_q = '0;
      sum_q   = '0;
    end else begin
      count_q = count_q + COUNT_W'(1);
    end
    r.corrected_temp = corr;
    r.heat_on        = heat_q;
    r.cool_on        = cool_q;
    r.overheat_alarm = alarm_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result check, then accepted requests into the predictor
  always @(posedge clk) begin
    hta_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected none, actual corrected %0d",
                   $time, out_corrected_temp);
        end else begin
          want = expected_results.pop_front();
          check_field("corrected_temp", want.corrected_temp, out_corrected_temp);
          check_field("average_ready", SAMPLE_W'(want.average_ready),
                      SAMPLE_W'(out_average_ready));
          check_field("averaged_temp", want.averaged_temp, out_averaged_temp);
          check_field("heat_on", SAMPLE_W'(want.heat_on), SAMPLE_W'(out_heat_on));
          check_field("cool_on", SAMPLE_W'(want.cool_on), SAMPLE_W'(out_cool_on));
          check_field("overheat_alarm", SAMPLE_W'(want.overheat_alarm),
                      SAMPLE_W'(out_overheat_alarm));
          if (want.average_ready) begin
            if (want.heat_on) heat_windows++;
            else if (want.cool_on) cool_windows++;
            else band_windows++;
          end
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(step_window(in_sensor_sample));
        samples_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  // request driver: holds a request until taken, idles in short bursts
  always @(negedge clk) begin
    logic drive;
    drive = 1'b0;
    if (rst_n && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 3);
      end else if (pending_samples.size() > 0) begin
        drive = 1'b1;
      end
      in_valid <= drive;
      if (drive) in_sensor_sample <= pending_samples.pop_front();
    end
  end

  // result receiver: short stall bursts plus one long hold-off
  always @(negedge clk) begin
    logic ready;
    ready = 1'b1;
    if (!hold_done && results_checked >= HOLD_AT_RESULT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      ready = 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 3);
      ready = 1'b0;
    end
    out_ready <= ready;
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    pending_samples.push_back(value);
    samples_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] clip_sample(input int value);
    if (value < 0) return '0;
    if (value > 255) return 8'd255;
    return SAMPLE_W'(value);
  endfunction

  // whole windows, mostly clustered around the set temperature
  task automatic queue_windows(input int count);
    int kind;
    int target;
    int level;
    for (int w = 0; w < count; w++) begin
      kind   = $urandom_range(0, 9);
      target = int'(setpoint_q) + int'($urandom_range(0, 24)) - 12;
      // raw level that lands near the target after both corrections
      level  = (target >= 10 && target < 100) ? target * 10 / 9 + 4 : target;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        if (kind < 7) push_sample(clip_sample(level + int'($urandom_range(0, 6)) - 3));
        else if (kind == 7) push_sample(SAMPLE_W'($urandom_range(0, 255)));
        else if (kind == 8) push_sample(SAMPLE_W'($urandom_range(0, 20)));
        else push_sample(SAMPLE_W'($urandom_range(int'(OVERHEAT_LEVEL), 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (samples_accepted != samples_queued || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_setpoint(input logic [SAMPLE_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    setpoint_q   = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // stimulus phases
  initial begin
    logic [SAMPLE_W-1:0] set_points[5];
    set_points[0] = 8'd0;
    set_points[1] = 8'd255;
    set_points[2] = 8'd4;
    set_points[3] = 8'd5;
    set_points[4] = SAMPLE_W'($urandom_range(10, 120));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every band edge, window average well below the set point
    foreach (set_points[i]) begin end
    push_sample(8'd0);   push_sample(8'd14);  push_sample(8'd15); push_sample(8'd31);
    push_sample(8'd32);  push_sample(8'd49);  push_sample(8'd50); push_sample(8'd67);
    push_sample(8'd68);  push_sample(8'd85);
    // top band, overheat and full scale, average above 100 asks for cooling
    push_sample(8'd86);  push_sample(8'd94);  push_sample(8'd95); push_sample(8'd255);
    repeat (6) push_sample(8'd94);

    queue_windows(WINDOWS_PER_PHASE);
    foreach (set_points[i]) begin
      write_setpoint(set_points[i]);
      queue_windows(WINDOWS_PER_PHASE);
    end

    // closing stretch at full rate
    wait_idle();
    idle_enable = 1'b0;
    write_setpoint(SAMPLE_W'($urandom_range(30, 90)));
    queue_windows(WINDOWS_PER_PHASE);
    wait_idle();

    $display("covered %0d samples over band edges, overheat and seven set points",
             samples_accepted);
    $display("windows closed: %0d heat, %0d cool, %0d in band",
             heat_windows, cool_windows, band_windows);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout with %0d of %0d requests taken", samples_accepted, samples_queued);
    $display("status: fail");
    $finish;
  end

endmodule
